// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define TLT_ASSERT_ALWAYS(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define TLT_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/tlt_pkg.sv =====
// Shared constants and widths for the two-link leg torque pipeline.
package tlt_pkg;
	// register indexes
	localparam logic [1:0] CFG_ASSIST     = 2'd0;
	localparam logic [1:0] CFG_HIP_GEAR   = 2'd1;
	localparam logic [1:0] CFG_KNEE_GEAR  = 2'd2;
	localparam logic [1:0] CFG_RATED      = 2'd3;

	localparam logic [15:0] ASSIST_RST = 16'd256;
	localparam logic [7:0]  GEAR_RST   = 8'd1;
	localparam logic [15:0] RATED_RST  = 16'd256;

	// angle to phase
	localparam logic signed [35:0] PHASE_MUL = 36'sd83443;
	localparam logic signed [35:0] PHASE_RND = 36'sd32768;
	localparam logic [15:0] QUARTER_TURN = 16'h4000;

	// sine polynomial, Q14
	localparam logic [14:0] SIN_ONE = 15'd16384;
	localparam logic [14:0] SIN_A   = 15'd25736;
	localparam logic [13:0] SIN_B   = 14'd10512;
	localparam logic [10:0] SIN_C   = 11'd1160;

	// link constants, Q16 Nm (base terms pre-shifted to Q30)
	localparam logic signed [32:0] MASS_DIAG_BASE_Q30 = 33'sd936837120;
	localparam logic signed [32:0] MASS_OFF_BASE_Q30  = 33'sd165085184;
	localparam logic signed [32:0] MASS_KNEE_Q30      = 33'sd165085184;
	localparam logic signed [16:0] MASS_DIAG_COS      = 17'sd37683;
	localparam logic signed [15:0] COUPLE             = 16'sd18842;
	localparam logic signed [21:0] GRAV_HIP           = 22'sd1109017;
	localparam logic signed [19:0] GRAV_SUM           = 20'sd369672;
	localparam logic signed [65:0] COR_DIV            = 66'sd4096;
	localparam logic [9:0]         PER_MILLE          = 10'd1000;

	// divider
	localparam int QBITS = 17;
	localparam int NUM_W = 42;
	localparam int DEN_W = 24;

	// valid stages ahead of the output register
	localparam int LAT = 10 + QBITS;

	localparam logic [15:0] CMD_MAX = 16'h7fff;
	localparam logic [15:0] CMD_MIN = 16'h8000;
endpackage

// ===== rtl/core/tlt_sin.sv =====
// Four-stage pipelined quarter-wave sine of a 16-bit phase, Q14 result.
module tlt_sin (
	input  logic               clk,
	input  logic               en,
	input  logic [15:0]        phase,
	output logic signed [15:0] sin_val
);
	logic [1:0]  quad_a, quad_b, quad_c;
	logic [14:0] x_a, x_b, x_c;
	logic [14:0] x2_a, x2_b;
	logic [13:0] t1_b;
	logic [14:0] t_c;
	logic [14:0] x;
	logic [29:0] xx;
	logic [25:0] x2c;
	logic [28:0] x2t;
	logic [29:0] xt;
	logic signed [15:0] s_pos;

	always_comb begin
		x   = phase[14] ? (tlt_pkg::SIN_ONE - {1'b0, phase[13:0]}) : {1'b0, phase[13:0]};
		xx  = 30'(x) * 30'(x);
		x2c = 26'(x2_a) * 26'(tlt_pkg::SIN_C);
		x2t = 29'(x2_b) * 29'(t1_b);
		xt  = 30'(x_c) * 30'(t_c);
		s_pos = $signed(xt[29:14]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quad_a <= phase[15:14];
			x_a    <= x;
			x2_a   <= xx[28:14];
			quad_b <= quad_a;
			x_b    <= x_a;
			x2_b   <= x2_a;
			t1_b   <= tlt_pkg::SIN_B - 14'(x2c[25:14]);
			quad_c <= quad_b;
			x_c    <= x_b;
			t_c    <= tlt_pkg::SIN_A - x2t[28:14];
			sin_val <= quad_c[1] ? -s_pos : s_pos;
		end
	end
endmodule

// ===== rtl/core/tlt_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module tlt_div (
	input  logic                       clk,
	input  logic                       en,
	input  logic [tlt_pkg::NUM_W-1:0]  num,
	input  logic [tlt_pkg::DEN_W-1:0]  den,
	output logic [tlt_pkg::QBITS-1:0]  quo,
	output logic                       ovf
);
	localparam int QB = tlt_pkg::QBITS;
	localparam int NW = tlt_pkg::NUM_W;
	localparam int DW = tlt_pkg::DEN_W;

	logic [NW-1:0] rem_q [QB];
	logic [DW-1:0] den_q [QB];
	logic [QB-1:0] quo_q [QB];
	logic [QB-1:0] ovf_q;

	for (genvar i = 0; i < QB; i++) begin : g_st
		logic [NW-1:0] r_in;
		logic [NW-1:0] dsh;
		logic [DW-1:0] d_in;
		logic [QB-1:0] q_in;
		logic          o_in;
		logic          ge;

		if (i == 0) begin : g_first
			assign r_in = num;
			assign d_in = den;
			assign q_in = '0;
			assign o_in = num >= (NW'(den) << QB);
		end else begin : g_next
			assign r_in = rem_q[i-1];
			assign d_in = den_q[i-1];
			assign q_in = quo_q[i-1];
			assign o_in = ovf_q[i-1];
		end

		assign dsh = NW'(d_in) << (QB - 1 - i);
		assign ge  = r_in >= dsh;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i] <= ge ? (r_in - dsh) : r_in;
				den_q[i] <= d_in;
				quo_q[i] <= q_in | (QB'(ge) << (QB - 1 - i));
				ovf_q[i] <= o_in;
			end
		end
	end

	assign quo = quo_q[QB-1];
	assign ovf = ovf_q[QB-1];
endmodule

// ===== rtl/core/two_link_leg_torque.sv =====
// Top level: two-link leg inverse dynamics and torque command pipeline.
//
//  channel  dir  handshake          payload
//  s_*      in   tvalid/tready      tdata: 6 x 16 bit kinematics, tuser: leg side
//  m_*      out  tvalid/tready      tdata: hip and knee command, tuser: side, clipped
//  cfg_*    in   cfg_we             cfg_index, cfg_data (16 bit)
//
// One beat per cycle sustained while the output beat is not held waiting.
// Depth is set by the four-stage sine units and the 17-stage quotient divider.
// The whole pipeline freezes while the output beat waits; nothing is lost.
// Reset clears the valid bits and loads the register defaults.
`include "assert_macros.svh"

module two_link_leg_torque (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // hip_angle, knee_angle, hip_velocity, knee_velocity,
	                               // hip_accel, knee_accel
	input  logic        s_tuser,   // leg_side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // hip_command, knee_command
	output logic [1:0]  m_tuser,   // side_echo, clipped
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	localparam int LAT = tlt_pkg::LAT;
	localparam int QB  = tlt_pkg::QBITS;

	logic en;
	logic [LAT-1:0] vld_q;

	logic [15:0] assist_q, rated_q;
	logic [7:0]  hip_gear_q, knee_gear_q;
	logic [7:0]  hip_gear_eff, knee_gear_eff;
	logic [15:0] rated_eff;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			assist_q    <= tlt_pkg::ASSIST_RST;
			hip_gear_q  <= tlt_pkg::GEAR_RST;
			knee_gear_q <= tlt_pkg::GEAR_RST;
			rated_q     <= tlt_pkg::RATED_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tlt_pkg::CFG_ASSIST:    assist_q    <= cfg_data;
				tlt_pkg::CFG_HIP_GEAR:  hip_gear_q  <= cfg_data[7:0];
				tlt_pkg::CFG_KNEE_GEAR: knee_gear_q <= cfg_data[7:0];
				tlt_pkg::CFG_RATED:     rated_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// zero divisor reads as one
	assign hip_gear_eff  = (hip_gear_q == '0) ? 8'd1 : hip_gear_q;
	assign knee_gear_eff = (knee_gear_q == '0) ? 8'd1 : knee_gear_q;
	assign rated_eff     = (rated_q == '0) ? 16'd1 : rated_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	// stage 1: phases
	logic signed [15:0] hip_ang, knee_ang;
	logic signed [16:0] sum_ang;
	logic signed [35:0] ph_hip_p, ph_knee_p, ph_sum_p;
	logic [15:0] ph_hip_s1, ph_knee_s1, ph_cos_s1, ph_sum_s1;
	logic signed [15:0] w1_s1, w2_s1;
	logic signed [15:0] acc_hip_q [1:6];
	logic signed [15:0] acc_knee_q [1:6];
	logic side_q [1:9];

	always_comb begin
		hip_ang   = $signed(s_tdata[15:0]);
		knee_ang  = $signed(s_tdata[31:16]);
		sum_ang   = 17'(hip_ang) + 17'(knee_ang);
		ph_hip_p  = 36'(hip_ang) * tlt_pkg::PHASE_MUL + tlt_pkg::PHASE_RND;
		ph_knee_p = 36'(knee_ang) * tlt_pkg::PHASE_MUL + tlt_pkg::PHASE_RND;
		ph_sum_p  = 36'(sum_ang) * tlt_pkg::PHASE_MUL + tlt_pkg::PHASE_RND;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ph_hip_s1  <= ph_hip_p[31:16];
			ph_knee_s1 <= ph_knee_p[31:16];
			ph_cos_s1  <= ph_knee_p[31:16] + tlt_pkg::QUARTER_TURN;
			ph_sum_s1  <= ph_sum_p[31:16];
			w1_s1      <= $signed(s_tdata[47:32]);
			w2_s1      <= $signed(s_tdata[63:48]);
			acc_hip_q[1]  <= $signed(s_tdata[79:64]);
			acc_knee_q[1] <= $signed(s_tdata[95:80]);
			side_q[1]     <= s_tuser;
			for (int i = 2; i <= 6; i++) begin
				acc_hip_q[i]  <= acc_hip_q[i-1];
				acc_knee_q[i] <= acc_knee_q[i-1];
			end
			for (int i = 2; i <= 9; i++) begin
				side_q[i] <= side_q[i-1];
			end
		end
	end

	// stages 2..5: sines
	logic signed [15:0] sin_hip, sin_knee, cos_knee, sin_sum;

	tlt_sin u_sin_hip  (.clk(clk), .en(en), .phase(ph_hip_s1),  .sin_val(sin_hip));
	tlt_sin u_sin_knee (.clk(clk), .en(en), .phase(ph_knee_s1), .sin_val(sin_knee));
	tlt_sin u_cos_knee (.clk(clk), .en(en), .phase(ph_cos_s1),  .sin_val(cos_knee));
	tlt_sin u_sin_sum  (.clk(clk), .en(en), .phase(ph_sum_s1),  .sin_val(sin_sum));

	// velocity products, stage 2, carried to stage 5
	logic signed [33:0] pw_q [2:5];
	logic signed [32:0] pk_q [2:5];
	logic signed [31:0] w12, w22, w11;

	always_comb begin
		w12 = 32'(w1_s1) * 32'(w2_s1);
		w22 = 32'(w2_s1) * 32'(w2_s1);
		w11 = 32'(w1_s1) * 32'(w1_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pw_q[2] <= (34'(w12) <<< 1) + 34'(w22);
			pk_q[2] <= 33'(w11);
			for (int i = 3; i <= 5; i++) begin
				pw_q[i] <= pw_q[i-1];
				pk_q[i] <= pk_q[i-1];
			end
		end
	end

	// stage 6: matrix, gravity, Coriolis partials
	logic signed [32:0] m00_s6, m01_s6;
	logic signed [37:0] g0_s6, g1_s6;
	logic signed [49:0] sp_s6, sk_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			m00_s6 <= tlt_pkg::MASS_DIAG_BASE_Q30 + 33'(tlt_pkg::MASS_DIAG_COS) * 33'(cos_knee);
			m01_s6 <= tlt_pkg::MASS_OFF_BASE_Q30 + 33'(tlt_pkg::COUPLE) * 33'(cos_knee);
			g0_s6  <= -(38'(tlt_pkg::GRAV_HIP) * 38'(sin_hip)
				+ 38'(tlt_pkg::GRAV_SUM) * 38'(sin_sum));
			g1_s6  <= -(38'(tlt_pkg::GRAV_SUM) * 38'(sin_sum));
			sp_s6  <= 50'(sin_knee) * 50'(pw_q[5]);
			sk_s6  <= 50'(sin_knee) * 50'(pk_q[5]);
		end
	end

	// stage 7: products with accelerations, Coriolis scaling
	logic signed [65:0] corp_hip, corp_knee;
	logic signed [49:0] hip_ma_s7, hip_mb_s7, knee_ma_s7, knee_mb_s7;
	logic signed [55:0] cor_hip_s7, cor_knee_s7;
	logic signed [37:0] g0_s7, g1_s7;

	always_comb begin
		corp_hip  = 66'(tlt_pkg::COUPLE) * 66'(sp_s6);
		corp_knee = 66'(tlt_pkg::COUPLE) * 66'(sk_s6);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hip_ma_s7   <= 50'(m00_s6) * 50'(acc_hip_q[6]);
			hip_mb_s7   <= 50'(m01_s6) * 50'(acc_knee_q[6]);
			knee_ma_s7  <= 50'(m01_s6) * 50'(acc_hip_q[6]);
			knee_mb_s7  <= 50'(tlt_pkg::MASS_KNEE_Q30) * 50'(acc_knee_q[6]);
			cor_hip_s7  <= 56'(-(corp_hip / tlt_pkg::COR_DIV));
			cor_knee_s7 <= 56'(corp_knee / tlt_pkg::COR_DIV);
			g0_s7       <= g0_s6;
			g1_s7       <= g1_s6;
		end
	end

	// stage 8: sums, magnitude in Q16, sign
	logic signed [56:0] hip38, knee38;
	logic [56:0] hip_abs, knee_abs;
	logic [31:0] hip_mag_s8, knee_mag_s8;
	logic hip_neg_s8, knee_neg_s8;

	always_comb begin
		hip38  = 57'(hip_ma_s7) + 57'(hip_mb_s7) + 57'(cor_hip_s7) + (57'(g0_s7) <<< 8);
		knee38 = 57'(knee_ma_s7) + 57'(knee_mb_s7) + 57'(cor_knee_s7) + (57'(g1_s7) <<< 8);
		hip_abs  = hip38[56] ? 57'(-hip38) : 57'(hip38);
		knee_abs = knee38[56] ? 57'(-knee38) : 57'(knee38);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hip_mag_s8  <= hip_abs[53:22];
			knee_mag_s8 <= knee_abs[53:22];
			hip_neg_s8  <= hip38[56] ^ side_q[7];
			knee_neg_s8 <= knee38[56] ^ !side_q[7];
		end
	end

	// stage 9: assist product, divisor
	logic [47:0] hip_pa_s9, knee_pa_s9;
	logic [23:0] hip_den_s9, knee_den_s9;
	logic hip_neg_s9, knee_neg_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			hip_pa_s9   <= 48'(hip_mag_s8) * 48'(assist_q);
			knee_pa_s9  <= 48'(knee_mag_s8) * 48'(assist_q);
			hip_den_s9  <= 24'(hip_gear_eff) * 24'(rated_eff);
			knee_den_s9 <= 24'(knee_gear_eff) * 24'(rated_eff);
			hip_neg_s9  <= hip_neg_s8;
			knee_neg_s9 <= knee_neg_s8;
		end
	end

	// stage 10: per-mille, drop the Q16 scale
	logic [57:0] hip_pm, knee_pm;
	logic [tlt_pkg::NUM_W-1:0] hip_num_s10, knee_num_s10;
	logic [tlt_pkg::DEN_W-1:0] hip_den_s10, knee_den_s10;

	always_comb begin
		hip_pm  = 58'(hip_pa_s9) * 58'(tlt_pkg::PER_MILLE);
		knee_pm = 58'(knee_pa_s9) * 58'(tlt_pkg::PER_MILLE);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hip_num_s10  <= hip_pm[57:16];
			knee_num_s10 <= knee_pm[57:16];
			hip_den_s10  <= hip_den_s9;
			knee_den_s10 <= knee_den_s9;
		end
	end

	// side and sign flags ride alongside the dividers
	logic [2:0] meta_q [QB + 1];

	always_ff @(posedge clk) begin
		if (en) begin
			meta_q[0] <= {side_q[9], hip_neg_s9, knee_neg_s9};
			for (int i = 1; i <= QB; i++) begin
				meta_q[i] <= meta_q[i-1];
			end
		end
	end

	// stages 11..27: quotients
	logic [QB-1:0] hip_quo, knee_quo;
	logic hip_ovf, knee_ovf;

	tlt_div u_div_hip (
		.clk(clk), .en(en), .num(hip_num_s10), .den(hip_den_s10),
		.quo(hip_quo), .ovf(hip_ovf)
	);

	tlt_div u_div_knee (
		.clk(clk), .en(en), .num(knee_num_s10), .den(knee_den_s10),
		.quo(knee_quo), .ovf(knee_ovf)
	);

	// output register: sign and saturation
	function automatic logic [16:0] sat_cmd(input logic [QB-1:0] q, input logic o,
		input logic neg);
		logic [16:0] r;
		logic [16:0] qn;
		qn = -17'(q);
		if (neg) begin
			if (o || q > 17'd32768) r = {1'b1, tlt_pkg::CMD_MIN};
			else r = {1'b0, qn[15:0]};
		end else begin
			if (o || q > 17'd32767) r = {1'b1, tlt_pkg::CMD_MAX};
			else r = {1'b0, q[15:0]};
		end
		return r;
	endfunction

	logic [16:0] hip_sat, knee_sat;
	logic [2:0]  meta_out;

	always_comb begin
		meta_out = meta_q[QB];
		hip_sat  = sat_cmd(hip_quo, hip_ovf, meta_out[1]);
		knee_sat = sat_cmd(knee_quo, knee_ovf, meta_out[0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= vld_q[LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= {knee_sat[15:0], hip_sat[15:0]};
			m_tuser <= {hip_sat[16] | knee_sat[16], meta_out[2]};
		end
	end

	`TLT_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, vld_q[0], "accepted beat missing in stage 1")
	`TLT_ASSERT_NEXT(a_stall_freezes, !en, $stable(vld_q), "pipeline moved during output stall")
	`TLT_ASSERT_ALWAYS(a_clip_at_limit,
		!(m_tvalid && m_tuser[1]) || m_tdata[15:0] == tlt_pkg::CMD_MAX
		|| m_tdata[15:0] == tlt_pkg::CMD_MIN || m_tdata[31:16] == tlt_pkg::CMD_MAX
		|| m_tdata[31:16] == tlt_pkg::CMD_MIN, "clipped set without a saturated command")
endmodule

// ===== tb/tb_two_link_leg_torque.sv =====
// Testbench for two_link_leg_torque: random and directed legs against a torque predictor.
module tb_two_link_leg_torque;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic               side;
		logic signed [15:0] hip_cmd;
		logic signed [15:0] knee_cmd;
		logic               clip;
	} torque_cmd_t;

	class torque_board;
		torque_cmd_t pending[$];
		logic [15:0] assist = 16'd256;
		logic [7:0]  hip_gear = 8'd1;
		logic [7:0]  knee_gear = 8'd1;
		logic [15:0] rated = 16'd256;
		int errors = 0;
		int matched = 0;

		function automatic longint phase_of(longint ang);
			longint b;
			b = ang * 83443 + 32768 + (longint'(1) << 40);
			return (b >>> 16) & 16'hFFFF;
		endfunction

		function automatic longint sine(longint ph);
			longint quad, w, x, x2, t, s;
			quad = (ph >> 14) & 3;
			w = ph & 16'h3FFF;
			x = (quad & 1) ? 16384 - w : w;
			x2 = (x * x) >> 14;
			t = 10512 - ((x2 * 1160) >> 14);
			t = 25736 - ((x2 * t) >> 14);
			s = (x * t) >> 14;
			return (quad >= 2) ? -s : s;
		endfunction

		function automatic longint scale(longint t38, longint gear, bit neg);
			longint t16, g, r, q;
			t16 = t38 / 4194304;
			g = gear ? gear : 1;
			r = rated ? longint'(rated) : 1;
			q = (t16 * longint'(assist) * 1000) / (g * r * 65536);
			return neg ? -q : q;
		endfunction

		function automatic logic [15:0] clamp(longint v, ref logic clip);
			if (v > 32767) begin
				v = 32767; clip = 1;
			end
			if (v < -32768) begin
				v = -32768; clip = 1;
			end
			return v[15:0];
		endfunction

		function automatic void note_leg(logic side, logic [95:0] d);
			longint q1, q2, w1, w2, a1, a2, s2, c2, s1, s12;
			longint m00, m01, m11, term, g0, g1, ch, ck, hip38, knee38;
			torque_cmd_t e;
			logic clip;
			q1 = $signed(d[15:0]);  q2 = $signed(d[31:16]);
			w1 = $signed(d[47:32]); w2 = $signed(d[63:48]);
			a1 = $signed(d[79:64]); a2 = $signed(d[95:80]);
			s2 = sine(phase_of(q2));
			c2 = sine((phase_of(q2) + 16'h4000) & 16'hFFFF);
			s1 = sine(phase_of(q1));
			s12 = sine(phase_of(q1 + q2));
			m00 = 57180 * 16384 + 37683 * c2;
			m01 = 10076 * 16384 + 18842 * c2;
			m11 = 10076 * 16384;
			term = 18842 * s2;
			g0 = -(1109017 * s1 + 369672 * s12);
			g1 = -(369672 * s12);
			ch = -((term * (2 * w1 * w2 + w2 * w2)) / 4096);
			ck = (term * (w1 * w1)) / 4096;
			hip38 = m00 * a1 + m01 * a2 + ch + g0 * 256;
			knee38 = m01 * a1 + m11 * a2 + ck + g1 * 256;
			clip = 0;
			e.side = side;
			e.hip_cmd = clamp(scale(hip38, hip_gear, side == 1), clip);
			e.knee_cmd = clamp(scale(knee38, knee_gear, side == 0), clip);
			e.clip = clip;
			pending.push_back(e);
		endfunction

		function automatic void check_cmd(logic [31:0] d, logic [1:0] u);
			torque_cmd_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected beat: tdata=%h tuser=%b", d, u);
				return;
			end
			e = pending.pop_front();
			if (u[0] !== e.side || d[15:0] !== e.hip_cmd || d[31:16] !== e.knee_cmd
					|| u[1] !== e.clip) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch: exp side=%0d hip=%0d knee=%0d clip=%0d,",
						" got side=%0d hip=%0d knee=%0d clip=%0d"},
						e.side, e.hip_cmd, e.knee_cmd, e.clip,
						u[0], $signed(d[15:0]), $signed(d[31:16]), u[1]);
			end else
				matched++;
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic s_tvalid = 0, s_tready, s_tuser = 0;
	logic [95:0] s_tdata = '0;
	logic m_tvalid, m_tready = 0;
	logic [31:0] m_tdata;
	logic [1:0] m_tuser;
	logic cfg_we = 0;
	logic [1:0] cfg_index = tlt_pkg::CFG_ASSIST;
	logic [15:0] cfg_data = '0;

	torque_board board = new();
	int idle_cycles = 0;
	int legs_sent = 0;
	bit hold_off = 0;

	two_link_leg_torque DUT (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic write_reg(logic [1:0] idx, logic [15:0] v);
		@(posedge clk);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			tlt_pkg::CFG_ASSIST:    board.assist = v;
			tlt_pkg::CFG_HIP_GEAR:  board.hip_gear = v[7:0];
			tlt_pkg::CFG_KNEE_GEAR: board.knee_gear = v[7:0];
			tlt_pkg::CFG_RATED:     board.rated = v;
			default: ;
		endcase
	endtask

	task automatic send_leg(logic side, logic [95:0] d, bit gaps);
		int g;
		g = gaps ? gap_len() : 0;
		if (g > 0) begin
			s_tvalid <= 0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1; s_tuser <= side; s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		board.note_leg(side, d);
		legs_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (tlt_pkg::LAT + 6) @(posedge clk);
	endtask

	function automatic logic [15:0] rnd_field(int mode);
		case (mode)
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($urandom_range(0, 2047) - 1024);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [95:0] rnd_leg();
		logic [95:0] d;
		int m;
		m = $urandom_range(0, 9);
		for (int i = 0; i < 6; i++)
			d[i*16 +: 16] = (m < 6) ? rnd_field(2 + (m & 1))
				: rnd_field($urandom_range(0, 3));
		return d;
	endfunction

	always @(posedge clk) begin
		if (!arst_n || hold_off)
			m_tready <= 0;
		else
			m_tready <= ($urandom_range(0, 9) < 7);
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) board.check_cmd(m_tdata, m_tuser);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("two_link_leg_torque verification failed");
			$finish;
		end
	end

	initial begin
		logic [15:0] assists[4] = '{16'd256, 16'd65535, 16'd0, 16'd4096};
		logic [15:0] gears[4]   = '{16'd1, 16'd255, 16'd0, 16'd7};
		logic [15:0] rateds[4]  = '{16'd256, 16'd1, 16'd65535, 16'd0};
		repeat (3) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// directed: extremes, both sides, zero input
		send_leg(0, '0, 0);
		send_leg(1, '0, 0);
		send_leg(0, {6{16'h7FFF}}, 0);
		send_leg(1, {6{16'h8000}}, 0);
		send_leg(1, {6{16'h7FFF}}, 0);
		send_leg(0, {6{16'h8000}}, 0);
		send_leg(0, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, 0);
		send_leg(1, {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, 0);
		send_leg(0, {16'h0100, 16'h0000, 16'h0400, 16'h0000, 16'h0000, 16'h3244}, 0);
		send_leg(1, {16'h0000, 16'h0100, 16'h0000, 16'h0400, 16'h3244, 16'h0000}, 0);

		// receiver stalls long while the sender keeps offering
		fork
			begin
				hold_off = 1;
				repeat (80) @(posedge clk);
				hold_off = 0;
			end
			repeat (60) send_leg(1'($urandom), rnd_leg(), 0);
		join
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			write_reg(tlt_pkg::CFG_ASSIST, ph < 4 ? assists[ph] : 16'($urandom));
			write_reg(tlt_pkg::CFG_HIP_GEAR,
				ph < 4 ? gears[ph] : 16'($urandom_range(1, 255)));
			write_reg(tlt_pkg::CFG_KNEE_GEAR,
				ph < 4 ? gears[3 - ph] : 16'($urandom_range(1, 255)));
			write_reg(tlt_pkg::CFG_RATED,
				ph < 4 ? rateds[ph] : 16'($urandom_range(1, 65535)));
			send_leg(0, {6{16'h7FFF}}, 0);
			send_leg(1, {6{16'h8000}}, 0);
			repeat (175) send_leg(1'($urandom), rnd_leg(), $urandom_range(0, 3) != 0);
			drain();
		end

		$display("Sent %0d legs over five register settings, %0d commands matched.",
			legs_sent, board.matched);
		if (board.errors == 0)
			$display("two_link_leg_torque verification clean");
		else
			$display("two_link_leg_torque verification failed");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/tlt_pkg.sv
rtl/core/tlt_sin.sv
rtl/core/tlt_div.sv
rtl/core/two_link_leg_torque.sv
tb/tb_two_link_leg_torque.sv
